### sv/swr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FIND_WORD,
		CFG_FIND_LEN,
		CFG_INSERT_WORD,
		CFG_INSERT_LEN
	} swr_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_FLUSH
	} swr_state_t;

	typedef struct packed {
		logic accept;
		logic emit_ins;
		logic emit_flush;
	} swr_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic hit_now;
		logic flush_now;
		logic ins_done;
		logic flush_done;
	} swr_status_t;

endpackage

`default_nettype wire

### sv/swr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       end_of_text;

	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface swr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

### sv/stream_word_replace.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming search and replace on a byte stream. Characters enter on text_in,
// one item per character, with end_of_text set on the last one of a sentence.
// Rewritten characters leave on text_out, with last_char set on the final one.
// The search and insert words and their lengths are written through the plain
// write port (cfg_we, cfg_index, cfg_data); the user must write them only while
// the block is idle, which the block does not enforce. Every write empties the
// match window. A character released when its item is taken appears in the
// next cycle, from an output register; insert and flush characters come from
// the sequencer, through its state register and then the output register.
// Text that does not complete a match flows at one item per cycle while the
// receiver does not stall. A match holds off the input while the insert word
// goes out character by character, and the end of a sentence while the
// characters still held in the window are flushed; the single output register
// and the insert and flush sequencer produce these characters.
// While the receiver stalls, the output register holds its item and no new
// item is taken. After reset the words and lengths are zero, so text passes
// through unchanged, and the window and output register are empty.
module stream_word_replace
	import swr_pkg::*;
#(
	parameter int MAX_WORD = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	swr_in_if.sink                      text_in,
	swr_out_if.source                   text_out
);

	swr_cmd_t    cmd;
	swr_status_t st;

	swr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.status   (st),
		.cmd      (cmd)
	);

	swr_datapath #(
		.MAX_WORD (MAX_WORD)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (text_in.text_char),
		.in_last   (text_in.end_of_text),
		.cmd       (cmd),
		.status    (st),
		.out_valid (text_out.valid),
		.out_ready (text_out.ready),
		.out_char  (text_out.out_char),
		.out_last  (text_out.last_char)
	);

	// A match must hold off the input while the insert word goes out.
	a_hit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.hit_now) |=> !text_in.ready)
		else $error("input taken straight after a match");

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ins || cmd.emit_flush) |-> !text_in.ready)
		else $error("input ready while the sequencer emits");

	a_output_from_command: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(text_out.valid) |-> $past(cmd.accept || cmd.emit_ins || cmd.emit_flush))
		else $error("output item without an emitting command");

endmodule

`default_nettype wire

### sv/swr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swr_ctrl
	import swr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  swr_status_t status,
	output swr_cmd_t   cmd
);

	swr_state_t state_q;
	swr_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.hit_now) begin
					state_next = ST_INSERT;
				end else if (cmd.accept && status.flush_now) begin
					state_next = ST_FLUSH;
				end
			end
			ST_INSERT: begin
				if (cmd.emit_ins && status.ins_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (cmd.emit_flush && status.flush_done) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ST_IDLE) && status.slot_free;
		cmd.accept     = in_ready && in_valid;
		cmd.emit_ins   = (state_q == ST_INSERT) && status.slot_free;
		cmd.emit_flush = (state_q == ST_FLUSH) && status.slot_free;
	end

endmodule

`default_nettype wire

### sv/swr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module swr_datapath
	import swr_pkg::*;
#(
	parameter int MAX_WORD = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [7:0]             in_char,
	input  wire logic                   in_last,
	input  swr_cmd_t                    cmd,
	output swr_status_t                 status,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  out_char,
	output logic                        out_last
);

	localparam int CW = $clog2(MAX_WORD + 1);
	localparam int WORD_W = 8 * MAX_WORD;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);

	logic [WORD_W-1:0] find_q;
	logic [WORD_W-1:0] insw_q;
	logic [LEN_W-1:0]  flen_q;
	logic [LEN_W-1:0]  ilen_q;
	logic [7:0]        win_q [MAX_WORD];
	logic [CW-1:0]     cnt_q;
	logic [WORD_W-1:0] ins_sh_q;
	logic [CW-1:0]     rem_q;
	logic              last_pend_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;
	logic              out_valid_q;

	logic [CW-1:0] flen;
	logic [CW-1:0] ilen;
	logic          enabled;
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_after;
	logic [7:0]    win_next [MAX_WORD];
	logic [7:0]    win_next_sh [MAX_WORD];
	logic [7:0]    win_sh [MAX_WORD];
	logic          hit;
	logic          full;
	logic          hit_now;
	logic          miss_now;
	logic          emission;

	always_comb begin
		flen = (flen_q > LEN_MAX) ? CW'(MAX_WORD) : flen_q[CW-1:0];
		ilen = (ilen_q > LEN_MAX) ? CW'(MAX_WORD) : ilen_q[CW-1:0];
		enabled = (flen != '0) && (ilen != '0);
		cnt_eff = (cnt_q >= flen) ? '0 : cnt_q;
		cnt_inc = cnt_eff + CW'(1);
		hit = 1'b1;
		for (int i = 0; i < MAX_WORD; i++) begin
			win_next[i] = (CW'(i) == cnt_eff) ? in_char : win_q[i];
			if ((CW'(i) < flen) && (win_next[i] != find_q[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
		for (int i = 0; i < MAX_WORD; i++) begin
			win_next_sh[i] = (i < MAX_WORD - 1) ? win_next[(i + 1) % MAX_WORD] : win_next[i];
			win_sh[i]      = (i < MAX_WORD - 1) ? win_q[(i + 1) % MAX_WORD] : win_q[i];
		end
		full      = (cnt_inc == flen);
		hit_now   = enabled && full && hit;
		miss_now  = enabled && full && !hit;
		cnt_after = hit_now ? '0 : (miss_now ? (flen - CW'(1)) : cnt_inc);
		emission  = (cmd.accept && (!enabled || miss_now)) || cmd.emit_ins || cmd.emit_flush;
	end

	always_comb begin
		status.slot_free  = !out_valid_q || out_ready;
		status.hit_now    = hit_now;
		status.flush_now  = enabled && in_last && !hit_now && (cnt_after != '0);
		status.ins_done   = (rem_q == CW'(1));
		status.flush_done = (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_q      <= '0;
			insw_q      <= '0;
			flen_q      <= '0;
			ilen_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (swr_cfg_t'(cfg_index))
					CFG_FIND_WORD:   find_q <= cfg_data[WORD_W-1:0];
					CFG_FIND_LEN:    flen_q <= cfg_data[LEN_W-1:0];
					CFG_INSERT_WORD: insw_q <= cfg_data[WORD_W-1:0];
					CFG_INSERT_LEN:  ilen_q <= cfg_data[LEN_W-1:0];
				endcase
				cnt_q <= '0;
			end else if (cmd.accept) begin
				cnt_q <= enabled ? cnt_after : '0;
			end else if (cmd.emit_flush) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (emission) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_pend_q <= in_last;
			if (!enabled) begin
				out_char_q <= in_char;
				out_last_q <= in_last;
			end else begin
				for (int i = 0; i < MAX_WORD; i++) begin
					win_q[i] <= miss_now ? win_next_sh[i] : win_next[i];
				end
				if (miss_now) begin
					out_char_q <= win_next[0];
					out_last_q <= in_last && (cnt_after == '0);
				end
				if (hit_now) begin
					ins_sh_q <= insw_q;
					rem_q    <= ilen;
				end
			end
		end else if (cmd.emit_ins) begin
			out_char_q <= ins_sh_q[7:0];
			out_last_q <= last_pend_q && (rem_q == CW'(1));
			ins_sh_q   <= ins_sh_q >> 8;
			rem_q      <= rem_q - CW'(1);
		end else if (cmd.emit_flush) begin
			out_char_q <= win_q[0];
			out_last_q <= (cnt_q == CW'(1));
			win_q      <= win_sh;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire
